// File: design/gpd_pkg.sv
// Shared constants, codes and types of the 3x3 grid peak detector.
`timescale 1ns / 1ps
package gpd_pkg;

	// Defaults of the top-level parameters
	localparam int DEF_MAX_DIM     = 128;
	localparam int DEF_HEIGHT_BITS = 16;

	// Grid size after reset (clamped to MAX_DIM at the top level)
	localparam int DEF_GRID_DIM = 128;

	// Configuration port
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

	// Result field widths and saturation limits
	localparam int POS_W  = 7;
	localparam int CNT_W  = 13;
	localparam int DIST_W = 20;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// Result kinds
	localparam logic KIND_PEAK    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Result queue
	localparam int RES_DEPTH = 8;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// Per-item control that travels down the pipeline
	typedef struct packed {
		logic             test;       // window center is an interior cell
		logic             frame_end;  // last cell of the frame
		logic [POS_W-1:0] prow;       // row of the window center
		logic [POS_W-1:0] pcol;       // column of the window center
	} item_tag_t;

	// Frame summary fields apart from the height
	typedef struct packed {
		logic              found;
		logic [CNT_W-1:0]  count;
		logic [DIST_W-1:0] path_len;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
	} summary_t;

endpackage

// File: design/gpd_line_store.sv
// Two line stores kept as one synchronous memory, with write-to-read forwarding.
`timescale 1ns / 1ps
module gpd_line_store
	import gpd_pkg::*;
#(
	parameter int ADDR_W      = 7,
	parameter int DEPTH       = 128,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [ADDR_W-1:0]             rd_addr,
	input  logic                          wr_en,
	input  logic [ADDR_W-1:0]             wr_addr,
	input  logic [2*HEIGHT_BITS-1:0]      wr_data,  // {middle, upper}
	output logic signed [HEIGHT_BITS-1:0] rd_upper,
	output logic signed [HEIGHT_BITS-1:0] rd_middle
);

	logic [2*HEIGHT_BITS-1:0] mem_q [DEPTH];
	logic [2*HEIGHT_BITS-1:0] rdat_q;
	logic [2*HEIGHT_BITS-1:0] wdat_q;
	logic                     fwd_q;
	logic [2*HEIGHT_BITS-1:0] rd_word;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdat_q <= mem_q[rd_addr];
		end
		wdat_q <= wr_data;
	end

	// a read that meets a write to the same entry sees the old word: take the new one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_word   = fwd_q ? wdat_q : rdat_q;
	assign rd_upper  = rd_word[HEIGHT_BITS-1:0];
	assign rd_middle = rd_word[2*HEIGHT_BITS-1:HEIGHT_BITS];

	a_fwd_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en && (wr_addr == rd_addr)) |=> fwd_q)
		else $error("line store: same-entry read not forwarded");

endmodule

// File: design/gpd_window.sv
// 3x3 window registers and the strict local-maximum test.
`timescale 1ns / 1ps
module gpd_window
	import gpd_pkg::*;
#(
	parameter int HEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          valid,
	input  item_tag_t                     tag,
	input  logic signed [HEIGHT_BITS-1:0] col_upper,
	input  logic signed [HEIGHT_BITS-1:0] col_middle,
	input  logic signed [HEIGHT_BITS-1:0] col_lower,
	output logic                          peak,
	output logic signed [HEIGHT_BITS-1:0] center
);

	// only the two newest columns are kept; the oldest one falls out on the shift
	logic signed [HEIGHT_BITS-1:0] mid_col_q [3];
	logic signed [HEIGHT_BITS-1:0] new_col_q [3];

	always_comb begin
		center = new_col_q[1];
		peak   = tag.test
			&& (mid_col_q[0] < center) && (mid_col_q[1] < center) && (mid_col_q[2] < center)
			&& (new_col_q[0] < center) && (new_col_q[2] < center)
			&& (col_upper < center) && (col_middle < center) && (col_lower < center);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				mid_col_q[i] <= '0;
				new_col_q[i] <= '0;
			end
		end else if (clear || (valid && tag.frame_end)) begin
			for (int i = 0; i < 3; i++) begin
				mid_col_q[i] <= '0;
				new_col_q[i] <= '0;
			end
		end else if (valid) begin
			for (int i = 0; i < 3; i++) begin
				mid_col_q[i] <= new_col_q[i];
			end
			new_col_q[0] <= col_upper;
			new_col_q[1] <= col_middle;
			new_col_q[2] <= col_lower;
		end
	end

endmodule

// File: design/gpd_stats.sv
// Frame statistics: highest peak, peak count and saturating path length.
`timescale 1ns / 1ps
module gpd_stats
	import gpd_pkg::*;
#(
	parameter int HEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          valid,
	input  logic                          peak,
	input  item_tag_t                     tag,
	input  logic signed [HEIGHT_BITS-1:0] center,
	output summary_t                      summary,
	output logic signed [HEIGHT_BITS-1:0] summary_height
);

	logic                          found_q;
	logic [POS_W-1:0]              best_row_q;
	logic [POS_W-1:0]              best_col_q;
	logic signed [HEIGHT_BITS-1:0] best_h_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [DIST_W-1:0]             dist_q;
	logic                          have_prev_q;
	logic [POS_W-1:0]              prev_row_q;
	logic [POS_W-1:0]              prev_col_q;

	logic              take;
	logic              better;
	logic [POS_W-1:0]  dr;
	logic [POS_W-1:0]  dc;
	logic [DIST_W:0]   dsum;
	logic [DIST_W-1:0] dist_nxt;
	logic [CNT_W-1:0]  cnt_nxt;

	always_comb begin
		take   = valid && peak;
		better = take && (!found_q || (center > best_h_q));
		dr     = (tag.prow > prev_row_q) ? tag.prow - prev_row_q : prev_row_q - tag.prow;
		dc     = (tag.pcol > prev_col_q) ? tag.pcol - prev_col_q : prev_col_q - tag.pcol;
		dsum   = (DIST_W+1)'(dist_q) + (DIST_W+1)'(dr) + (DIST_W+1)'(dc);
		if (take && have_prev_q) begin
			dist_nxt = (dsum > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX : dsum[DIST_W-1:0];
		end else begin
			dist_nxt = dist_q;
		end
		cnt_nxt = (take && (cnt_q != CNT_MAX)) ? cnt_q + 1'b1 : cnt_q;

		// summary reflects the item that closes the frame
		summary.found    = found_q || take;
		summary.count    = cnt_nxt;
		summary.path_len = dist_nxt;
		summary.row      = better ? tag.prow : best_row_q;
		summary.col      = better ? tag.pcol : best_col_q;
		summary_height   = better ? center : best_h_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			best_row_q  <= '0;
			best_col_q  <= '0;
			best_h_q    <= '0;
			cnt_q       <= '0;
			dist_q      <= '0;
			have_prev_q <= 1'b0;
			prev_row_q  <= '0;
			prev_col_q  <= '0;
		end else if (clear || (valid && tag.frame_end)) begin
			found_q     <= 1'b0;
			best_row_q  <= '0;
			best_col_q  <= '0;
			best_h_q    <= '0;
			cnt_q       <= '0;
			dist_q      <= '0;
			have_prev_q <= 1'b0;
			prev_row_q  <= '0;
			prev_col_q  <= '0;
		end else if (take) begin
			found_q     <= 1'b1;
			best_row_q  <= summary.row;
			best_col_q  <= summary.col;
			best_h_q    <= summary_height;
			cnt_q       <= cnt_nxt;
			dist_q      <= dist_nxt;
			have_prev_q <= 1'b1;
			prev_row_q  <= tag.prow;
			prev_col_q  <= tag.pcol;
		end
	end

	a_first_peak_is_best: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !found_q && !clear) |-> better)
		else $error("stats: first peak of frame not taken as best");

endmodule

// File: design/gpd_result_fifo.sv
// Small result queue that takes up to two items per cycle and hands out one.
`timescale 1ns / 1ps
module gpd_result_fifo
	import gpd_pkg::*;
#(
	parameter int ENTRY_W = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_a,
	input  logic [ENTRY_W-1:0]   data_a,
	input  logic                 push_b,   // only together with push_a
	input  logic [ENTRY_W-1:0]   data_b,
	input  logic                 pop,
	output logic                 not_empty,
	output logic [ENTRY_W-1:0]   head,
	output logic [RES_CNT_W-1:0] count
);

	logic [ENTRY_W-1:0]   mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wp_q;
	logic [RES_PTR_W-1:0] rp_q;
	logic [RES_CNT_W-1:0] count_q;
	logic [RES_PTR_W-1:0] wp_b;
	logic                 do_pop;

	assign wp_b      = wp_q + 1'b1;
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rp_q];
	assign count     = count_q;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wp_q] <= data_a;
		end
		if (push_a && push_b) begin
			mem_q[wp_b] <= data_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + RES_PTR_W'(push_a) + RES_PTR_W'(push_a && push_b);
			rp_q    <= rp_q + RES_PTR_W'(do_pop);
			count_q <= count_q + RES_CNT_W'(push_a) + RES_CNT_W'(push_a && push_b)
				- RES_CNT_W'(do_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RES_CNT_W'(RES_DEPTH))
		else $error("result queue: overflow");

	a_b_needs_a: assert property (@(posedge clk) disable iff (!arst_n)
		push_b |-> push_a)
		else $error("result queue: second push without first");

endmodule

// File: design/grid_peak_detector_3x3_core.sv
// Top level of the 3x3 grid peak detector.
`timescale 1ns / 1ps
// Takes a height grid in raster order, one signed height per input item, and reports
// every interior cell that is strictly higher than all eight neighbors, in raster
// order, as a peak item (tuser = 0). On the last cell of a frame it adds a summary
// item (tuser = 1): the first highest peak, the peak count and the saturating sum of
// Manhattan distances between consecutive peaks. tlast marks the final result item
// that one input item causes. The grid size comes from grid_rows (index 0) and
// grid_cols (index 1); 0 reads as 1 and values above MAX_DIM read as MAX_DIM, and any
// write restarts the frame. Write the registers only while no item is in flight.
// Rate: one input item per clock unless input is held off. The two line stores share one memory
// word per column, read when the item is taken and written back from stage 1; that single
// read/modify/write per column sets the rate. A peak is found in stage 1 when the cell
// below and to the right of it is taken, and is queued from stage 2. A result queue
// of eight entries decouples the output; input is held off only when the queue could
// not absorb the worst case of the items still in the pipeline. No clearing pass
// follows reset: line store entries are always written before they are tested.
module grid_peak_detector_3x3_core
	import gpd_pkg::*;
#(
	parameter int MAX_DIM     = DEF_MAX_DIM,
	parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
	localparam int IN_TDATA_W  = ((HEIGHT_BITS + 7) / 8) * 8,
	localparam int OUT_FIELD_W = 2 * POS_W + HEIGHT_BITS + 1 + CNT_W + DIST_W,
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_wdata,
	// input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // height
	// result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // row, col, peak_height, found,
	                                               // peak_count, path_distance
	output logic [0:0]             m_axis_tuser,   // kind
	output logic                   m_axis_tlast    // last
);

	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int ADDR_W  = $clog2(MAX_DIM);
	localparam int CMP_W   = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int RESET_DIM = (DEF_GRID_DIM > MAX_DIM) ? MAX_DIM : DEF_GRID_DIM;
	localparam int ENTRY_W = OUT_FIELD_W + 2;
	localparam int OCC_W   = RES_CNT_W + 2;

	// ---------------------------------------------------------------- configuration
	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] cols_q;
	logic [CMP_W-1:0] cfg_ext;
	logic [DIM_W-1:0] cfg_dim;

	// clamp the written size into 1..MAX_DIM
	always_comb begin
		cfg_ext = CMP_W'(cfg_wdata);
		if (cfg_ext == '0) begin
			cfg_dim = DIM_W'(1);
		end else if (cfg_ext > CMP_W'(MAX_DIM)) begin
			cfg_dim = DIM_W'(MAX_DIM);
		end else begin
			cfg_dim = DIM_W'(cfg_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_W'(RESET_DIM);
			cols_q <= DIM_W'(RESET_DIM);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_ROWS: rows_q <= cfg_dim;
				REG_GRID_COLS: cols_q <= cfg_dim;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- raster position
	logic             in_fire;
	logic [DIM_W-1:0] row_q;
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;
	logic             row_wrap;
	logic             frame_end;
	item_tag_t        tag_in;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_comb begin
		col_inc   = col_q + 1'b1;
		row_inc   = row_q + 1'b1;
		row_wrap  = (col_inc >= cols_q);
		frame_end = row_wrap && (row_inc >= rows_q);
		// the window center sits one row up and one column left of the new cell
		tag_in.test      = (row_q >= DIM_W'(2)) && (col_q >= DIM_W'(2));
		tag_in.frame_end = frame_end;
		tag_in.prow      = POS_W'(row_q - 1'b1);
		tag_in.pcol      = POS_W'(col_q - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_we) begin
			// any register write restarts the frame
			row_q <= '0;
			col_q <= '0;
		end else if (in_fire) begin
			if (frame_end) begin
				row_q <= '0;
				col_q <= '0;
			end else if (row_wrap) begin
				row_q <= row_inc;
				col_q <= '0;
			end else begin
				col_q <= col_inc;
			end
		end
	end

	// ---------------------------------------------------------------- stage 1: window
	logic                          v_s1;
	item_tag_t                     tag_s1;
	logic [ADDR_W-1:0]             addr_s1;
	logic signed [HEIGHT_BITS-1:0] h_s1;
	logic signed [HEIGHT_BITS-1:0] ls_upper;
	logic signed [HEIGHT_BITS-1:0] ls_middle;
	logic                          peak_s1;
	logic signed [HEIGHT_BITS-1:0] center_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			tag_s1  <= tag_in;
			addr_s1 <= col_q[ADDR_W-1:0];
			h_s1    <= s_axis_tdata[HEIGHT_BITS-1:0];
		end
	end

	// read the column on accept, write it back shifted one row down in stage 1
	gpd_line_store #(
		.ADDR_W      (ADDR_W),
		.DEPTH       (MAX_DIM),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_fire),
		.rd_addr   (col_q[ADDR_W-1:0]),
		.wr_en     (v_s1),
		.wr_addr   (addr_s1),
		.wr_data   ({h_s1, ls_middle}),
		.rd_upper  (ls_upper),
		.rd_middle (ls_middle)
	);

	gpd_window #(
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cfg_we),
		.valid      (v_s1),
		.tag        (tag_s1),
		.col_upper  (ls_upper),
		.col_middle (ls_middle),
		.col_lower  (h_s1),
		.peak       (peak_s1),
		.center     (center_s1)
	);

	// ---------------------------------------------------------------- stage 2: statistics
	logic                          v_s2;
	logic                          peak_s2;
	item_tag_t                     tag_s2;
	logic signed [HEIGHT_BITS-1:0] center_s2;
	summary_t                      summary;
	logic signed [HEIGHT_BITS-1:0] summary_height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			peak_s2 <= 1'b0;
		end else begin
			v_s2    <= v_s1;
			peak_s2 <= v_s1 && peak_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			tag_s2    <= tag_s1;
			center_s2 <= center_s1;
		end
	end

	gpd_stats #(
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_stats (
		.clk            (clk),
		.arst_n         (arst_n),
		.clear          (cfg_we),
		.valid          (v_s2),
		.peak           (peak_s2),
		.tag            (tag_s2),
		.center         (center_s2),
		.summary        (summary),
		.summary_height (summary_height)
	);

	// ---------------------------------------------------------------- result queue
	logic [OUT_FIELD_W-1:0] peak_fields;
	logic [OUT_FIELD_W-1:0] sum_fields;
	logic [ENTRY_W-1:0]     peak_entry;
	logic [ENTRY_W-1:0]     sum_entry;
	logic                   push_peak;
	logic                   push_sum;
	logic                   push_a;
	logic                   push_b;
	logic [ENTRY_W-1:0]     data_a;
	logic [ENTRY_W-1:0]     head;
	logic [RES_CNT_W-1:0]   res_count;
	logic [OCC_W-1:0]       occupancy;

	always_comb begin
		push_peak = v_s2 && peak_s2;
		push_sum  = v_s2 && tag_s2.frame_end;
		// fields from the lowest bit up: row, col, height, found, count, distance
		peak_fields = {DIST_W'(0), CNT_W'(0), 1'b0, center_s2, tag_s2.pcol, tag_s2.prow};
		sum_fields  = {summary.path_len, summary.count, summary.found, summary_height,
			summary.col, summary.row};
		// entry: {kind, last, fields}; a peak is last unless the summary follows it
		peak_entry = {KIND_PEAK, !push_sum, peak_fields};
		sum_entry  = {KIND_SUMMARY, 1'b1, sum_fields};
		// a peak always goes ahead of the summary of the same item
		push_a = push_peak || push_sum;
		push_b = push_peak && push_sum;
		data_a = push_peak ? peak_entry : sum_entry;
	end

	gpd_result_fifo #(
		.ENTRY_W (ENTRY_W)
	) u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (push_a),
		.data_a    (data_a),
		.push_b    (push_b),
		.data_b    (sum_entry),
		.pop       (m_axis_tready),
		.not_empty (m_axis_tvalid),
		.head      (head),
		.count     (res_count)
	);

	assign m_axis_tdata    = OUT_TDATA_W'(head[OUT_FIELD_W-1:0]);
	assign m_axis_tlast    = head[OUT_FIELD_W];
	assign m_axis_tuser[0] = head[OUT_FIELD_W+1];

	// hold off input unless the queue can take two results for every item in flight
	assign occupancy = OCC_W'(res_count) + {v_s1, 1'b0} + {v_s2, 1'b0};
	assign s_axis_tready = (occupancy <= OCC_W'(RES_DEPTH - 2));

	// ---------------------------------------------------------------- checks
	a_no_adjacent_peaks: assert property (@(posedge clk) disable iff (!arst_n)
		push_peak |=> !push_peak)
		else $error("core: peaks reported for two consecutive cells");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && frame_end) |=> (row_q == '0) && (col_q == '0))
		else $error("core: raster position not cleared at frame end");

	a_summary_follows_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && frame_end && !cfg_we) |=> ##1 push_sum)
		else $error("core: frame end without summary");

endmodule
